// ===== hdl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache simulator.
// No dependencies.
package salc_pkg;

  localparam int MaxSetBitsDef = 6;
  localparam int MaxWaysDef    = 8;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_IFETCH = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_EVICT = 2'd2,
    OUT_IGN   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    REG_SET_BITS   = 2'd0,
    REG_WAYS       = 2'd1,
    REG_BLOCK_BITS = 2'd2,
    REG_NONE       = 2'd3
  } reg_e;

  typedef struct packed {
    logic        ignore;
    logic        modify;
    logic [63:0] blk;
  } cmd_t;

endpackage

// ===== hdl/salc_front.sv =====
// Front end: accepts trace words, strips the block offset, queues commands.
// Depends on salc_pkg.
module salc_front import salc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [5:0]  block_bits_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] address_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_ptr_q, rd_ptr_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q].ignore <= (action_e'(action_i) == ACT_IFETCH);
      q_q[wr_ptr_q].modify <= (action_e'(action_i) == ACT_MODIFY);
      q_q[wr_ptr_q].blk    <= address_i >> block_bits_i;
    end
  end

endmodule

// ===== hdl/salc_back.sv =====
// Back end: set read, LRU update and write back, counters, output register.
// Depends on salc_pkg.
module salc_back import salc_pkg::*; #(
  parameter int MaxSetBits = MaxSetBitsDef,
  parameter int MaxWays    = MaxWaysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  set_bits_i,
  input  logic [3:0]  ways_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic        second_hit_o,
  output logic [31:0] total_hits_o,
  output logic [31:0] total_misses_o,
  output logic [31:0] total_evictions_o
);

  localparam int Sets  = 1 << MaxSetBits;
  localparam int SW    = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int WW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int CW    = $clog2(MaxWays + 1);
  localparam int RowW  = MaxWays * 65;
  localparam logic [1:0] ST_IDLE = 2'd0, ST_CMP = 2'd1;

  logic [RowW-1:0] mem_q [Sets];
  logic [RowW-1:0] rd_q;
  logic [Sets-1:0] row_ok_q;
  logic [1:0] st_q;
  logic [SW-1:0] set_q;
  logic [63:0] tag_q;
  logic modify_q;
  logic [31:0] hit_q, miss_q, evic_q;
  logic [1:0] out_q;
  logic sec_q, ovalid_q;

  logic [3:0] sb_eff;
  logic [CW-1:0] nw;
  logic [63:0] blk_shift;
  logic [SW-1:0] set_idx;

  always_comb begin
    sb_eff = (int'(set_bits_i) > MaxSetBits) ? 4'(MaxSetBits) : {1'b0, set_bits_i};
    if (ways_i == 4'd0) nw = CW'(1);
    else if (int'(ways_i) > MaxWays) nw = CW'(MaxWays);
    else nw = CW'(ways_i);
    blk_shift = cmd_i.blk >> sb_eff;
    set_idx = SW'(cmd_i.blk & ((64'd1 << sb_eff) - 64'd1));
  end

  logic          v   [MaxWays];
  logic [63:0]   t   [MaxWays];
  logic          hit;
  logic [WW-1:0] pos;
  logic          full;
  logic [RowW-1:0] new_row;

  always_comb begin
    logic stop;
    hit  = 1'b0;
    full = 1'b1;
    pos  = WW'(int'(nw) - 1);
    stop = 1'b0;
    for (int i = 0; i < MaxWays; i++) begin
      v[i] = rd_q[i*65+64] && row_ok_q[set_q];
      t[i] = rd_q[i*65 +: 64];
    end
    for (int i = 0; i < MaxWays; i++) begin
      if (!stop && i < int'(nw)) begin
        if (!v[i]) begin
          stop = 1'b1; full = 1'b0; pos = WW'(i);
        end else if (t[i] == tag_q) begin
          stop = 1'b1; hit = 1'b1; full = 1'b0; pos = WW'(i);
        end
      end
    end
    for (int i = 0; i < MaxWays; i++) begin
      if (i == 0) new_row[0 +: 65] = {1'b1, tag_q};
      else if (i <= int'(pos)) new_row[i*65 +: 65] = {v[i-1], t[i-1]};
      else new_row[i*65 +: 65] = {v[i], t[i]};
    end
  end

  assign cmd_ready_o = (st_q == ST_IDLE) && !cmd_i.ignore ? 1'b1 :
                       (st_q == ST_IDLE) && !ovalid_q;
  assign out_valid_o      = ovalid_q;
  assign outcome_o        = out_q;
  assign second_hit_o     = sec_q;
  assign total_hits_o     = hit_q;
  assign total_misses_o   = miss_q;
  assign total_evictions_o = evic_q;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && cmd_valid_i && !cmd_i.ignore) begin
      rd_q  <= mem_q[set_idx];
      set_q <= set_idx;
      tag_q <= blk_shift;
      modify_q <= cmd_i.modify;
    end
    if (st_q == ST_CMP && (!ovalid_q || out_ready_i)) mem_q[set_q] <= new_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      row_ok_q <= '0;
      hit_q <= '0; miss_q <= '0; evic_q <= '0;
      out_q <= OUT_IGN; sec_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            if (cmd_i.ignore) begin
              out_q <= OUT_IGN; sec_q <= 1'b0; ovalid_q <= 1'b1;
            end else begin
              st_q <= ST_CMP;
            end
          end
        end
        ST_CMP: begin
          if (!ovalid_q || out_ready_i) begin
            row_ok_q[set_q] <= 1'b1;
            st_q <= ST_IDLE;
            ovalid_q <= 1'b1;
            sec_q <= modify_q;
            if (hit) begin
              out_q <= OUT_HIT;
              hit_q <= hit_q + (modify_q ? 32'd2 : 32'd1);
            end else begin
              out_q <= full ? OUT_EVICT : OUT_MISS;
              miss_q <= miss_q + 32'd1;
              if (modify_q) hit_q <= hit_q + 32'd1;
              if (full) evic_q <= evic_q + 32'd1;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/set_assoc_lru_cache_sim_core.sv =====
// Top level of the set-associative LRU cache simulator: APB registers,
// front end and back end. Depends on salc_pkg, salc_front, salc_back.
// In the back end each access reads its set row, then compares, reorders for
// LRU and writes the row back in one row-wide memory; modify finishes in the
// same pass since its store always hits. Instruction fetches skip the row
// read. A two-entry queue separates intake from the back end. The store is
// cleared at reset through one valid bit per set; no clearing pass is needed.
module set_assoc_lru_cache_sim_core import salc_pkg::*; #(
  parameter int MaxSetBits = MaxSetBitsDef,
  parameter int MaxWays    = MaxWaysDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  outcome_o,
  output logic        second_hit_o,
  output logic [31:0] total_hits_o,
  output logic [31:0] total_misses_o,
  output logic [31:0] total_evictions_o
);

  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  reg_e ridx;

  assign pready = 1'b1;
  assign ridx = (paddr[3:2] == 2'd0) ? REG_SET_BITS :
                (paddr[3:2] == 2'd1) ? REG_WAYS :
                (paddr[3:2] == 2'd2) ? REG_BLOCK_BITS : REG_NONE;

  always_comb begin
    unique case (ridx)
      REG_SET_BITS:   prdata = {29'd0, set_bits_q};
      REG_WAYS:       prdata = {28'd0, ways_q};
      REG_BLOCK_BITS: prdata = {26'd0, block_bits_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd4; ways_q <= 4'd1; block_bits_q <= 6'd4;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_SET_BITS:   set_bits_q   <= pwdata[2:0];
        REG_WAYS:       ways_q       <= pwdata[3:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk_i, .rst_ni, .block_bits_i(block_bits_q),
    .in_valid_i, .in_ready_o, .action_i, .address_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  salc_back #(.MaxSetBits(MaxSetBits), .MaxWays(MaxWays)) u_back (
    .clk_i, .rst_ni, .set_bits_i(set_bits_q), .ways_i(ways_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .out_valid_o, .out_ready_i, .outcome_o, .second_hit_o,
    .total_hits_o, .total_misses_o, .total_evictions_o
  );

endmodule
